// ----- rtl/rgb_to_hsv_converter_unit_macros.svh -----
// Assertion macros shared by the RGB to HSV converter RTL.
`ifndef RGB_TO_HSV_CONVERTER_UNIT_MACROS_SVH
`define RGB_TO_HSV_CONVERTER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising clock edge, skipped while reset is held.
`define HSV_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");
// Check a property on every rising clock edge, reset included.
`define HSV_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");
`else
`define HSV_ASSERT(label, clk, rst_n, prop)
`define HSV_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ----- rtl/hsv_pkg.sv -----
// Shared types and constants of the RGB to HSV converter.
package hsv_pkg;

  // Default widths of one color component and of the hue/saturation fraction
  localparam int HSV_COMPONENT_BITS = 8;
  localparam int HSV_FRACTION_BITS  = 16;

  // Hue offset after the swaps, in sixths of a turn
  typedef enum logic [1:0] {
    K_ZERO = 2'd0,
    K_NEG6 = 2'd1,
    K_NEG2 = 2'd2,
    K_POS4 = 2'd3
  } offset_t;

  // Special-case flags that ride along with an item through the dividers
  typedef struct packed {
    logic hue_zero;
    logic sat_zero;
  } hsv_flags_t;

endpackage

// ----- rtl/hsv_in_if.sv -----
// Pixel input channel: valid/ready handshake with three color components.
interface hsv_in_if #(
  parameter int COMPONENT_BITS = 8
) ();
  logic                      valid;
  logic                      ready;
  logic [COMPONENT_BITS-1:0] red_in;
  logic [COMPONENT_BITS-1:0] green_in;
  logic [COMPONENT_BITS-1:0] blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in,
                  output ready);
endinterface

// ----- rtl/hsv_out_if.sv -----
// Result channel: valid/ready handshake with hue, saturation and value.
interface hsv_out_if #(
  parameter int COMPONENT_BITS = 8,
  parameter int FRACTION_BITS  = 16
) ();
  logic                      valid;
  logic                      ready;
  logic [FRACTION_BITS-1:0]  hue_out;
  logic [FRACTION_BITS-1:0]  saturation_out;
  logic [COMPONENT_BITS-1:0] value_out;

  modport source (output valid, output hue_out, output saturation_out,
                  output value_out, input ready);
  modport sink   (input valid, input hue_out, input saturation_out,
                  input value_out, output ready);
endinterface

// ----- rtl/hsv_front.sv -----
// Front end: sort the components, form chroma, then hue numerator and divisors.
module hsv_front
  import hsv_pkg::*;
#(
  parameter int COMPONENT_BITS = HSV_COMPONENT_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [COMPONENT_BITS-1:0] in_red,
  input  logic [COMPONENT_BITS-1:0] in_green,
  input  logic [COMPONENT_BITS-1:0] in_blue,
  output logic                      out_valid,
  input  logic                      out_ready,
  output hsv_flags_t                out_flags,
  output logic [COMPONENT_BITS-1:0] out_value,
  output logic [COMPONENT_BITS+3:0] out_p_h,
  output logic [COMPONENT_BITS+2:0] out_den_h,
  output logic [COMPONENT_BITS:0]   out_p_s,
  output logic [COMPONENT_BITS-1:0] out_den_s
);

`include "rgb_to_hsv_converter_unit_macros.svh"

  localparam int CB = COMPONENT_BITS;

  // Stage 1: swapped components and offset
  logic          s1_valid_r;
  logic [CB-1:0] s1_r_r, s1_g_r, s1_b_r;
  offset_t       s1_k_r;
  logic [CB-1:0] s1_r_nxt, s1_g_nxt, s1_b_nxt;
  offset_t       s1_k_nxt;
  logic          s1_ready;

  // Stage 2: value, chroma, remaining pair and offset
  logic          s2_valid_r;
  logic [CB-1:0] s2_r_r, s2_g_r, s2_b_r, s2_c_r;
  offset_t       s2_k_r;
  logic [CB-1:0] s2_c_nxt;
  logic          s2_ready;

  // Stage 3: hue numerator magnitude and both divisors
  logic          s3_valid_r;
  logic [CB-1:0] s3_value_r, s3_c_r;
  logic [CB+2:0] s3_mag_r, s3_den_r;
  logic [CB+2:0] s3_mag_nxt, s3_den_nxt;
  logic          s3_ready;

  logic signed [CB+3:0] c_ext, kc, diff, num, neg_num;

  // Chain the stage readies: a stage moves when it is empty or its successor moves
  assign s3_ready = !s3_valid_r || out_ready;
  assign s2_ready = !s2_valid_r || s3_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_ready = s1_ready;

  // Order the components with up to two swaps, tracking the offset
  always_comb begin
    s1_r_nxt = in_red;
    s1_g_nxt = in_green;
    s1_b_nxt = in_blue;
    s1_k_nxt = K_ZERO;
    if (in_green < in_blue) begin
      s1_g_nxt = in_blue;
      s1_b_nxt = in_green;
      s1_k_nxt = K_NEG6;
    end
    if (in_red < s1_g_nxt) begin
      s1_r_nxt = s1_g_nxt;
      s1_g_nxt = in_red;
      s1_k_nxt = (s1_k_nxt == K_NEG6) ? K_POS4 : K_NEG2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_r_r <= s1_r_nxt;
      s1_g_r <= s1_g_nxt;
      s1_b_r <= s1_b_nxt;
      s1_k_r <= s1_k_nxt;
    end
  end

  // Chroma is the largest minus the smaller of the other two
  assign s2_c_nxt = (s1_g_r < s1_b_r) ? (s1_r_r - s1_g_r) : (s1_r_r - s1_b_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_r_r <= s1_r_r;
      s2_g_r <= s1_g_r;
      s2_b_r <= s1_b_r;
      s2_c_r <= s2_c_nxt;
      s2_k_r <= s1_k_r;
    end
  end

  // Form |K*chroma + (g - b)| with shifts and 6*chroma for the hue divisor
  always_comb begin
    c_ext = signed'({4'b0000, s2_c_r});
    case (s2_k_r)
      K_ZERO:  kc = '0;
      K_NEG6:  kc = -((c_ext <<< 2) + (c_ext <<< 1));
      K_NEG2:  kc = -(c_ext <<< 1);
      K_POS4:  kc = c_ext <<< 2;
      default: kc = '0;
    endcase
    diff    = signed'({4'b0000, s2_g_r}) - signed'({4'b0000, s2_b_r});
    num     = kc + diff;
    neg_num = -num;
    s3_mag_nxt = num[CB+3] ? neg_num[CB+2:0] : num[CB+2:0];
    s3_den_nxt = {1'b0, s2_c_r, 2'b00} + {2'b00, s2_c_r, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (s3_ready) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready) begin
      s3_value_r <= s2_r_r;
      s3_c_r     <= s2_c_r;
      s3_mag_r   <= s3_mag_nxt;
      s3_den_r   <= s3_den_nxt;
    end
  end

  // Hand the dividends and divisors to the divider chain
  assign out_valid          = s3_valid_r;
  assign out_flags.hue_zero = (s3_c_r == '0);
  assign out_flags.sat_zero = (s3_value_r == '0);
  assign out_value          = s3_value_r;
  assign out_p_h            = {1'b0, s3_mag_r};
  assign out_den_h          = s3_den_r;
  assign out_p_s            = {1'b0, s3_c_r};
  assign out_den_s          = s3_value_r;

  `HSV_ASSERT(a_sort_max, clk, rst_n, s1_valid_r |-> (s1_r_r >= s1_g_r && s1_r_r >= s1_b_r))
  `HSV_ASSERT(a_mag_bound, clk, rst_n, s3_valid_r |-> (s3_mag_r <= s3_den_r))

endmodule

// ----- rtl/hsv_div_step.sv -----
// One restoring-division stage: one quotient bit for hue and one for saturation.
module hsv_div_step
  import hsv_pkg::*;
#(
  parameter int COMPONENT_BITS = HSV_COMPONENT_BITS,
  parameter int FRACTION_BITS  = HSV_FRACTION_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  hsv_flags_t                in_flags,
  input  logic [COMPONENT_BITS-1:0] in_value,
  input  logic [COMPONENT_BITS+3:0] in_p_h,
  input  logic [COMPONENT_BITS+2:0] in_den_h,
  input  logic [FRACTION_BITS:0]    in_q_h,
  input  logic [COMPONENT_BITS:0]   in_p_s,
  input  logic [COMPONENT_BITS-1:0] in_den_s,
  input  logic [FRACTION_BITS:0]    in_q_s,
  output logic                      out_valid,
  input  logic                      out_ready,
  output hsv_flags_t                out_flags,
  output logic [COMPONENT_BITS-1:0] out_value,
  output logic [COMPONENT_BITS+3:0] out_p_h,
  output logic [COMPONENT_BITS+2:0] out_den_h,
  output logic [FRACTION_BITS:0]    out_q_h,
  output logic [COMPONENT_BITS:0]   out_p_s,
  output logic [COMPONENT_BITS-1:0] out_den_s,
  output logic [FRACTION_BITS:0]    out_q_s
);

`include "rgb_to_hsv_converter_unit_macros.svh"

  localparam int WH = COMPONENT_BITS + 3;
  localparam int WS = COMPONENT_BITS;

  logic          valid_r;
  hsv_flags_t    flags_r;
  logic [WS-1:0] value_r;
  logic [WH:0]   p_h_r;
  logic [WH-1:0] den_h_r;
  logic [FRACTION_BITS:0] q_h_r;
  logic [WS:0]   p_s_r;
  logic [WS-1:0] den_s_r;
  logic [FRACTION_BITS:0] q_s_r;

  logic          bit_h, bit_s;
  logic [WH:0]   rem_h;
  logic [WS:0]   rem_s;
  logic [WH:0]   p_h_nxt;
  logic [WS:0]   p_s_nxt;

  assign in_ready = !valid_r || out_ready;

  // Compare, subtract on success, then double the remainder for the next bit
  always_comb begin
    bit_h   = (in_p_h >= {1'b0, in_den_h});
    rem_h   = bit_h ? (in_p_h - {1'b0, in_den_h}) : in_p_h;
    p_h_nxt = {rem_h[WH-1:0], 1'b0};
    bit_s   = (in_p_s >= {1'b0, in_den_s});
    rem_s   = bit_s ? (in_p_s - {1'b0, in_den_s}) : in_p_s;
    p_s_nxt = {rem_s[WS-1:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      flags_r <= in_flags;
      value_r <= in_value;
      p_h_r   <= p_h_nxt;
      den_h_r <= in_den_h;
      q_h_r   <= {in_q_h[FRACTION_BITS-1:0], bit_h};
      p_s_r   <= p_s_nxt;
      den_s_r <= in_den_s;
      q_s_r   <= {in_q_s[FRACTION_BITS-1:0], bit_s};
    end
  end

  assign out_valid = valid_r;
  assign out_flags = flags_r;
  assign out_value = value_r;
  assign out_p_h   = p_h_r;
  assign out_den_h = den_h_r;
  assign out_q_h   = q_h_r;
  assign out_p_s   = p_s_r;
  assign out_den_s = den_s_r;
  assign out_q_s   = q_s_r;

  `HSV_ASSERT(a_rem_h_bound, clk, rst_n, (valid_r && den_h_r != '0) |-> (p_h_r < {den_h_r, 1'b0}))
  `HSV_ASSERT(a_rem_s_bound, clk, rst_n, (valid_r && den_s_r != '0) |-> (p_s_r < {den_s_r, 1'b0}))

endmodule

// ----- rtl/hsv_back.sv -----
// Back end: clamp the quotients, apply the gray and black cases, hold the result.
module hsv_back
  import hsv_pkg::*;
#(
  parameter int COMPONENT_BITS = HSV_COMPONENT_BITS,
  parameter int FRACTION_BITS  = HSV_FRACTION_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  hsv_flags_t                in_flags,
  input  logic [COMPONENT_BITS-1:0] in_value,
  input  logic [FRACTION_BITS:0]    in_q_h,
  input  logic [FRACTION_BITS:0]    in_q_s,
  hsv_out_if.source                 out_px
);

`include "rgb_to_hsv_converter_unit_macros.svh"

  localparam int FB = FRACTION_BITS;

  logic                      valid_r;
  logic [FB-1:0]             hue_r, sat_r;
  logic [COMPONENT_BITS-1:0] value_r;
  logic [FB-1:0]             hue_nxt, sat_nxt;

  assign in_ready = !valid_r || out_px.ready;

  // Clamp a full-scale quotient to all ones; force zero for gray or black
  always_comb begin
    if (in_flags.hue_zero) begin
      hue_nxt = '0;
    end else if (in_q_h[FB]) begin
      hue_nxt = '1;
    end else begin
      hue_nxt = in_q_h[FB-1:0];
    end
    if (in_flags.sat_zero) begin
      sat_nxt = '0;
    end else if (in_q_s[FB]) begin
      sat_nxt = '1;
    end else begin
      sat_nxt = in_q_s[FB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      hue_r   <= hue_nxt;
      sat_r   <= sat_nxt;
      value_r <= in_value;
    end
  end

  assign out_px.valid          = valid_r;
  assign out_px.hue_out        = hue_r;
  assign out_px.saturation_out = sat_r;
  assign out_px.value_out      = value_r;

  `HSV_ASSERT(a_q_h_range, clk, rst_n, (in_valid && !in_flags.hue_zero) |-> (!in_q_h[FB] || in_q_h[FB-1:0] == '0))
  `HSV_ASSERT(a_black_sat, clk, rst_n, (valid_r && value_r == '0) |-> (sat_r == '0))

endmodule

// ----- rtl/rgb_to_hsv_converter_unit.sv -----
// Top level of the RGB to HSV converter: front end, divider chain, output stage.
//
// Converts one RGB pixel per clock into hue, saturation (both fractions of
// 2^FRACTION_BITS, clamped to all ones) and value (largest component). The
// pipeline takes a new pixel every cycle while the result side keeps up; a
// stalled result holds in the output register and the stages fill their
// bubbles before input ready drops. The pipeline holds
// three front stages (sort, chroma, numerator and divisors), FRACTION_BITS + 1
// restoring-division stages that each settle one quotient bit of both hue and
// saturation, and the output register. Reset only clears the valid bits.
module rgb_to_hsv_converter_unit
  import hsv_pkg::*;
#(
  parameter int COMPONENT_BITS = HSV_COMPONENT_BITS,
  parameter int FRACTION_BITS  = HSV_FRACTION_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  hsv_in_if.sink    in_px,
  hsv_out_if.source out_px
);

  localparam int CB    = COMPONENT_BITS;
  localparam int FB    = FRACTION_BITS;
  localparam int NSTEP = FRACTION_BITS + 1;

  // Links between stages; index 0 is the front end output
  logic          link_valid [NSTEP+1];
  logic          link_ready [NSTEP+1];
  hsv_flags_t    link_flags [NSTEP+1];
  logic [CB-1:0] link_value [NSTEP+1];
  logic [CB+3:0] link_p_h   [NSTEP+1];
  logic [CB+2:0] link_den_h [NSTEP+1];
  logic [FB:0]   link_q_h   [NSTEP+1];
  logic [CB:0]   link_p_s   [NSTEP+1];
  logic [CB-1:0] link_den_s [NSTEP+1];
  logic [FB:0]   link_q_s   [NSTEP+1];

  // Sort, chroma and divisor preparation
  hsv_front #(
    .COMPONENT_BITS(CB)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_px.valid),
    .in_ready  (in_px.ready),
    .in_red    (in_px.red_in),
    .in_green  (in_px.green_in),
    .in_blue   (in_px.blue_in),
    .out_valid (link_valid[0]),
    .out_ready (link_ready[0]),
    .out_flags (link_flags[0]),
    .out_value (link_value[0]),
    .out_p_h   (link_p_h[0]),
    .out_den_h (link_den_h[0]),
    .out_p_s   (link_p_s[0]),
    .out_den_s (link_den_s[0])
  );

  // Start both quotients empty
  assign link_q_h[0] = '0;
  assign link_q_s[0] = '0;

  // One quotient bit per stage
  for (genvar i = 0; i < NSTEP; i++) begin : g_div
    hsv_div_step #(
      .COMPONENT_BITS(CB),
      .FRACTION_BITS (FB)
    ) u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (link_valid[i]),
      .in_ready  (link_ready[i]),
      .in_flags  (link_flags[i]),
      .in_value  (link_value[i]),
      .in_p_h    (link_p_h[i]),
      .in_den_h  (link_den_h[i]),
      .in_q_h    (link_q_h[i]),
      .in_p_s    (link_p_s[i]),
      .in_den_s  (link_den_s[i]),
      .in_q_s    (link_q_s[i]),
      .out_valid (link_valid[i+1]),
      .out_ready (link_ready[i+1]),
      .out_flags (link_flags[i+1]),
      .out_value (link_value[i+1]),
      .out_p_h   (link_p_h[i+1]),
      .out_den_h (link_den_h[i+1]),
      .out_q_h   (link_q_h[i+1]),
      .out_p_s   (link_p_s[i+1]),
      .out_den_s (link_den_s[i+1]),
      .out_q_s   (link_q_s[i+1])
    );
  end

  // Clamp, special cases and output register
  hsv_back #(
    .COMPONENT_BITS(CB),
    .FRACTION_BITS (FB)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (link_valid[NSTEP]),
    .in_ready (link_ready[NSTEP]),
    .in_flags (link_flags[NSTEP]),
    .in_value (link_value[NSTEP]),
    .in_q_h   (link_q_h[NSTEP]),
    .in_q_s   (link_q_s[NSTEP]),
    .out_px   (out_px)
  );

endmodule
